// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Expect clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define RMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RMQ_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rmq_pkg.sv =====
// Shared types and constants for the matrix-to-quaternion pipeline.
// No dependencies.
`default_nettype none
package rmq_pkg;
  localparam int unsigned DW       = 16;
  localparam int unsigned RAD_W    = 17;
  localparam int unsigned ROOT_W   = 24;
  localparam int unsigned REM_W    = 27;
  localparam int unsigned SQ_STEPS = 24;
  localparam int unsigned SQ_SHIFT = 31;
  localparam int unsigned NUM_W    = 18;
  localparam int unsigned MAG_W    = 17;
  localparam int unsigned Q_W      = 17;
  localparam int unsigned DIV_W    = 42;
  localparam int unsigned FRAC_SH  = 23;
  localparam int unsigned LANES    = 3;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  typedef struct packed {
    logic [1:0]                  br;
    logic                        flag;
    logic [LANES-1:0][NUM_W-1:0] num;
  } side_t;

  typedef struct packed {
    logic [LANES-1:0][Q_W-1:0] q;
    logic [LANES-1:0]          ovf;
    logic [ROOT_W-1:0]         g;
    side_t                     side;
  } divres_t;
endpackage
`default_nettype wire

// ===== sv/rmq_front.sv =====
// Trace, branch choice, radicand and numerators; one register stage.
// Depends on rmq_pkg.
`default_nettype none
module rmq_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_vld,
  input  wire logic signed [rmq_pkg::DW-1:0] m11, m12, m13,
  input  wire logic signed [rmq_pkg::DW-1:0] m21, m22, m23,
  input  wire logic signed [rmq_pkg::DW-1:0] m31, m32, m33,
  output logic                               vld_r,
  output logic [rmq_pkg::RAD_W-1:0]          rad_r,
  output rmq_pkg::side_t                     side_r
);
  logic signed [17:0] tr;
  logic signed [18:0] rad;
  logic signed [17:0] dxw, dyw, dzw, sxy, sxz, syz;
  logic [1:0] br;
  logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W-1:0] num;
  logic [rmq_pkg::RAD_W-1:0] rad_nxt;
  rmq_pkg::side_t side_nxt;

  always_comb begin
    tr  = 18'(m11) + 18'(m22) + 18'(m33);
    dxw = 18'(m32) - 18'(m23);
    dyw = 18'(m13) - 18'(m31);
    dzw = 18'(m21) - 18'(m12);
    sxy = 18'(m12) + 18'(m21);
    sxz = 18'(m13) + 18'(m31);
    syz = 18'(m23) + 18'(m32);
    if (tr > 18'sd0) begin
      br  = rmq_pkg::BR_TRACE;
      rad = 19'sd32768 + 19'(tr);
      num = {dzw, dyw, dxw};
    end else if (m11 > m22 && m11 > m33) begin
      br  = rmq_pkg::BR_X;
      rad = 19'sd32768 + 19'(m11) - 19'(m22) - 19'(m33);
      num = {sxz, sxy, dxw};
    end else if (m22 > m33) begin
      br  = rmq_pkg::BR_Y;
      rad = 19'sd32768 + 19'(m22) - 19'(m11) - 19'(m33);
      num = {syz, sxy, dyw};
    end else begin
      br  = rmq_pkg::BR_Z;
      rad = 19'sd32768 + 19'(m33) - 19'(m11) - 19'(m22);
      num = {syz, sxz, dzw};
    end
    side_nxt.br   = br;
    side_nxt.num  = num;
    side_nxt.flag = rad[18];
    rad_nxt       = rad[18] ? '0 : rad[rmq_pkg::RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      side_r <= side_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== sv/rmq_sqrt.sv =====
// Pipelined integer square root of rad * 2^31, one result bit per stage.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_vld,
  input  wire logic [rmq_pkg::RAD_W-1:0]  in_rad,
  input  wire rmq_pkg::side_t             in_side,
  output logic                            out_vld,
  output logic [rmq_pkg::ROOT_W-1:0]      out_g,
  output rmq_pkg::side_t                  out_side
);
  localparam int unsigned N = rmq_pkg::SQ_STEPS;

  logic                          vld_r  [N];
  logic [rmq_pkg::RAD_W-1:0]     rad_r  [N];
  logic [rmq_pkg::REM_W-1:0]     rem_r  [N];
  logic [rmq_pkg::ROOT_W-1:0]    root_r [N];
  rmq_pkg::side_t                side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic                        v_in;
    logic [rmq_pkg::RAD_W-1:0]   rad_in;
    logic [rmq_pkg::REM_W-1:0]   rem_in, rem_sh, trial, rem_nxt;
    logic [rmq_pkg::ROOT_W-1:0]  root_in, root_nxt;
    rmq_pkg::side_t              side_in;
    logic [2*N-1:0]              v48;

    if (k == 0) begin : g_first
      assign v_in    = in_vld;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      v48    = {rad_in, {rmq_pkg::SQ_SHIFT{1'b0}}};
      rem_sh = {rem_in[rmq_pkg::REM_W-3:0], v48[2*(N-1-k)+1 -: 2]};
      trial  = rmq_pkg::REM_W'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[rmq_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[rmq_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_in;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_g    = root_r[N-1];
  assign out_side = side_r[N-1];
endmodule
`default_nettype wire

// ===== sv/rmq_div.sv =====
// Three-lane pipelined restoring divider: |n| * 2^23 + g over 2g,
// 17 quotient bits plus an overflow bit. Depends on rmq_pkg.
`default_nettype none
module rmq_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_vld,
  input  wire logic [rmq_pkg::ROOT_W-1:0] in_g,
  input  wire rmq_pkg::side_t           in_side,
  output logic                          out_vld,
  output rmq_pkg::divres_t              out_res
);
  localparam int unsigned QN = rmq_pkg::Q_W;
  localparam int unsigned L  = rmq_pkg::LANES;
  localparam int unsigned W  = rmq_pkg::DIV_W;

  logic                       pre_vld_r;
  logic [L-1:0][W-1:0]        pre_rem_r;
  rmq_pkg::divres_t           pre_res_r;
  rmq_pkg::divres_t           pre_res_nxt;
  logic [L-1:0][W-1:0]        pre_rem_nxt;

  always_comb begin
    logic signed [rmq_pkg::NUM_W-1:0] n;
    logic [rmq_pkg::MAG_W-1:0]        mag;
    pre_res_nxt      = '0;
    pre_res_nxt.g    = in_g;
    pre_res_nxt.side = in_side;
    for (int i = 0; i < L; i++) begin
      n   = $signed(in_side.num[i]);
      mag = n[rmq_pkg::NUM_W-1] ? rmq_pkg::MAG_W'(-n) : rmq_pkg::MAG_W'(n);
      pre_rem_nxt[i] = (W'(mag) << rmq_pkg::FRAC_SH) + W'(in_g);
      pre_res_nxt.ovf[i] = pre_rem_nxt[i] >= (W'(in_g) << (QN + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (en) begin
      pre_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_rem_r <= pre_rem_nxt;
      pre_res_r <= pre_res_nxt;
    end
  end

  logic                 vld_r [QN];
  logic [L-1:0][W-1:0]  rem_r [QN];
  rmq_pkg::divres_t     res_r [QN];

  for (genvar k = 0; k < QN; k++) begin : g_step
    logic                 v_in;
    logic [L-1:0][W-1:0]  rem_in, rem_nxt;
    rmq_pkg::divres_t     res_in, res_nxt;
    logic [W-1:0]         dsh;

    if (k == 0) begin : g_first
      assign v_in   = pre_vld_r;
      assign rem_in = pre_rem_r;
      assign res_in = pre_res_r;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    always_comb begin
      dsh     = W'(res_in.g) << (QN - k);
      rem_nxt = rem_in;
      res_nxt = res_in;
      for (int i = 0; i < L; i++) begin
        if (rem_in[i] >= dsh) begin
          rem_nxt[i] = rem_in[i] - dsh;
          res_nxt.q[i][QN-1-k] = 1'b1;
        end else begin
          res_nxt.q[i][QN-1-k] = 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign out_vld = vld_r[QN-1];
  assign out_res = res_r[QN-1];
endmodule
`default_nettype wire

// ===== sv/rmq_back.sv =====
// Saturation, zero-divisor handling and component placement; output register.
// Depends on rmq_pkg.
`default_nettype none
module rmq_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_vld,
  input  wire rmq_pkg::divres_t        in_res,
  output logic                         vld_r,
  output logic [rmq_pkg::DW-1:0]       qw_r, qx_r, qy_r, qz_r,
  output logic [1:0]                   br_r,
  output logic                         deg_r
);
  localparam logic [15:0] POS_MAX = 16'h7fff;
  localparam logic [15:0] NEG_MAX = 16'h8000;

  logic [3:0][15:0] comp;
  logic [2:0][15:0] lane;
  logic             flag;
  logic [rmq_pkg::ROOT_W:0] own_sum;
  logic [15:0]      own;
  logic             gz;

  always_comb begin
    logic signed [rmq_pkg::NUM_W-1:0] n;
    logic [rmq_pkg::Q_W-1:0]          q;
    int unsigned                      j;
    gz      = (in_res.g == '0);
    flag    = in_res.side.flag | gz;
    own_sum = (rmq_pkg::ROOT_W+1)'(in_res.g) + 25'd256;
    if (own_sum[24:9] > 16'd32767) begin
      own  = POS_MAX;
      flag = 1'b1;
    end else begin
      own = own_sum[24:9];
    end
    for (int i = 0; i < rmq_pkg::LANES; i++) begin
      n = $signed(in_res.side.num[i]);
      q = in_res.q[i];
      if (gz) begin
        if (n > 0)      lane[i] = POS_MAX;
        else if (n < 0) lane[i] = NEG_MAX;
        else            lane[i] = '0;
      end else if (!n[rmq_pkg::NUM_W-1]) begin
        if (in_res.ovf[i] || q > 17'd32767) begin
          lane[i] = POS_MAX;
          flag    = 1'b1;
        end else begin
          lane[i] = q[15:0];
        end
      end else begin
        if (in_res.ovf[i] || q > 17'd32768) begin
          lane[i] = NEG_MAX;
          flag    = 1'b1;
        end else begin
          lane[i] = 16'(-q);
        end
      end
    end
    j = 0;
    for (int c = 0; c < 4; c++) begin
      if (2'(c) == in_res.side.br) begin
        comp[c] = own;
      end else begin
        comp[c] = lane[j];
        j = j + 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw_r  <= comp[0];
      qx_r  <= comp[1];
      qy_r  <= comp[2];
      qz_r  <= comp[3];
      br_r  <= in_res.side.br;
      deg_r <= flag;
    end
  end
endmodule
`default_nettype wire

// ===== sv/rotation_matrix_to_quaternion_unit.sv =====
// Rotation matrix to quaternion, 44-stage pipeline.
// Stages: 1 front, 24 square-root bit stages, 1 divider setup,
// 17 divider bit stages, 1 output register. Throughput one request per cycle when
// not stalled: the whole pipeline holds while the output request is not taken.
// Synchronous active-low reset clears all valid bits; no other reset state.
`default_nettype none
module rotation_matrix_to_quaternion_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_m11, in_m12, in_m13,
  input  wire logic [15:0] in_m21, in_m22, in_m23,
  input  wire logic [15:0] in_m31, in_m32, in_m33,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_qw, out_qx, out_qy, out_qz,
  output logic [1:0]       out_branch_taken,
  output logic             out_degenerate
);
  logic                            en;
  logic                            f_vld, s_vld, d_vld;
  logic [rmq_pkg::RAD_W-1:0]       f_rad;
  rmq_pkg::side_t                  f_side, s_side;
  logic [rmq_pkg::ROOT_W-1:0]      s_g;
  rmq_pkg::divres_t                d_res;

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  rmq_front u_front (
    .clk, .rst_n, .en,
    .in_vld (in_valid),
    .m11 (in_m11), .m12 (in_m12), .m13 (in_m13),
    .m21 (in_m21), .m22 (in_m22), .m23 (in_m23),
    .m31 (in_m31), .m32 (in_m32), .m33 (in_m33),
    .vld_r (f_vld), .rad_r (f_rad), .side_r (f_side)
  );

  rmq_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_vld (f_vld), .in_rad (f_rad), .in_side (f_side),
    .out_vld (s_vld), .out_g (s_g), .out_side (s_side)
  );

  rmq_div u_div (
    .clk, .rst_n, .en,
    .in_vld (s_vld), .in_g (s_g), .in_side (s_side),
    .out_vld (d_vld), .out_res (d_res)
  );

  rmq_back u_back (
    .clk, .rst_n, .en,
    .in_vld (d_vld), .in_res (d_res),
    .vld_r (out_valid),
    .qw_r (out_qw), .qx_r (out_qx), .qy_r (out_qy), .qz_r (out_qz),
    .br_r (out_branch_taken), .deg_r (out_degenerate)
  );
endmodule
`default_nettype wire

// ===== sv/rmq_checker.sv =====
// Port-level checks for rotation_matrix_to_quaternion_unit, bound to the top.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rmq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_qw, out_qx, out_qy, out_qz,
  input wire logic [1:0]  out_branch_taken,
  input wire logic        out_degenerate
);
  `RMQ_ASSERT_ANY(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")
  `RMQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_qw) && $stable(out_qx) && $stable(out_qy) && $stable(out_qz) && $stable(out_branch_taken) && $stable(out_degenerate), "stalled output request changed")
  `RMQ_ASSERT(a_own_nonneg, out_valid |-> !((out_branch_taken == 2'd0 && out_qw[15]) || (out_branch_taken == 2'd1 && out_qx[15]) || (out_branch_taken == 2'd2 && out_qy[15]) || (out_branch_taken == 2'd3 && out_qz[15])), "branch component negative")
  `RMQ_ASSERT(a_ready_stall, out_valid && !out_ready |-> !in_ready, "input taken while pipeline held")
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready,
  .out_qw, .out_qx, .out_qy, .out_qz, .out_branch_taken, .out_degenerate
);
`default_nettype wire
